[rtl/hid_report_to_midi_diff_unit_macros.svh]
// Assertion helpers used by the top-level RTL block.
`ifndef HID_REPORT_TO_MIDI_DIFF_UNIT_MACROS_SVH
`define HID_REPORT_TO_MIDI_DIFF_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRMD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrmd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HRMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrmd next-cycle check failed");

`endif

[rtl/hrmd_pkg.sv]
package hrmd_pkg;

  localparam int REPORT_BYTES = 22;

  localparam logic [7:0] NOTE_ON     = 8'h90;
  localparam logic [7:0] CTRL_CHANGE = 8'hB0;

  localparam logic [6:0] PAD_NOTE_BASE  = 7'd60;
  localparam logic [6:0] STOP_NOTE_BASE = 7'd76;
  localparam logic [6:0] LEVEL_CC_BASE  = 7'd1;
  localparam logic [6:0] BUTTON_CC_BASE = 7'd10;
  localparam logic [6:0] VALUE_ON       = 7'd127;
  localparam logic [6:0] VALUE_OFF      = 7'd0;

  // Emission slots: pads, stops, levels, buttons.
  localparam int NUM_SLOTS   = 38;
  localparam int SLOT_STOP   = 16;
  localparam int SLOT_LEVEL  = 20;
  localparam int SLOT_BUTTON = 29;
  localparam int NUM_LEVELS  = 9;
  localparam int NUM_SWITCH  = 29;

  typedef logic [NUM_SLOTS-1:0] slot_vec_t;

endpackage

[rtl/hrmd_report_buf.sv]
module hrmd_report_buf #(
  parameter int ReportBytes = hrmd_pkg::REPORT_BYTES,
  localparam int AddrW = $clog2(ReportBytes)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [7:0]       wr_data,
  input  logic             wr_last,
  output logic             report_done,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       rd_data
);
  import hrmd_pkg::*;

  localparam int CntW = $clog2(ReportBytes + 2);
  localparam logic [CntW-1:0] FullCount = CntW'(ReportBytes);
  localparam logic [CntW-1:0] OverCount = CntW'(ReportBytes + 1);

  logic [7:0]      mem [ReportBytes];
  logic [CntW-1:0] count;

  // A report completes when its end mark lands on the last byte slot.
  assign report_done = wr_en && wr_last && (count == FullCount - CntW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr_en) begin
      if (wr_last) begin
        count <= '0;
      end else if (count < FullCount) begin
        count <= count + CntW'(1);
      end else begin
        count <= OverCount;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (count < FullCount)) begin
      mem[count[AddrW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/hid_report_to_midi_diff_unit.sv]
// Controller report to MIDI change messages.
//
// The slave channel takes one report byte per beat in tdata, with tlast on
// the final byte of a transfer. Bytes are written into a 22-entry report
// buffer at one beat per cycle while the block is idle. A transfer whose
// final beat is not exactly the 22nd byte is dropped without output.
// On a complete report the block stops taking beats and reads the buffer
// back (21 reads, one per cycle, through a registered read port), builds
// the switch word and the nine level readings, and marks every control
// that differs from its stored previous value. It then scans the 38
// controls in message order, one per cycle, and places one MIDI message
// per change in the master output register; tlast marks the final one.
// When the receiver stalls, the scan waits on the held beat. Reset clears
// the byte count, the previous switches and levels, and empties the output.
`include "hid_report_to_midi_diff_unit_macros.svh"

module hid_report_to_midi_diff_unit #(
  parameter int ReportBytes = hrmd_pkg::REPORT_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] report_byte
  input  logic        s_tlast,   // end_of_report
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] status_byte, [14:8] control_number,
                                 // [21:15] control_value, [23:22] zero
  output logic        m_tlast    // last_of_run
);
  import hrmd_pkg::*;

  localparam int AddrW = $clog2(ReportBytes);
  localparam int LvlW  = $clog2(NUM_LEVELS);
  localparam int SlotW = $clog2(NUM_SLOTS);

  localparam logic [AddrW-1:0] AddrPadsLo  = AddrW'(1);
  localparam logic [AddrW-1:0] AddrPadsHi  = AddrW'(2);
  localparam logic [AddrW-1:0] AddrButtons = AddrW'(3);
  localparam logic [AddrW-1:0] AddrStops   = AddrW'(4);
  localparam logic [AddrW-1:0] AddrSelect  = AddrW'(5);
  localparam logic [AddrW-1:0] AddrLevel0  = AddrW'(6);
  localparam logic [AddrW-1:0] AddrLast    = AddrW'(ReportBytes - 1);

  // Byte (3 or 4) and bit of each button, in controller-number order.
  localparam logic [8:0]      BtnInFour = 9'b0_0100_0110;
  localparam int unsigned     BtnBit [9] = '{3, 1, 2, 6, 7, 4, 3, 5, 2};

  typedef enum logic [1:0] {IDLE, GATHER, EMIT} state_t;

  state_t                state;
  logic                  report_done;
  logic                  rd_en;
  logic [AddrW-1:0]      issue_addr;
  logic                  issue_done;
  logic                  rd_vld;
  logic [AddrW-1:0]      rd_addr_q;
  logic [7:0]            rd_data;
  logic [7:0]            b1, b2, b3, b4, lo_q;
  logic [NUM_SWITCH-1:0] prev_switches;
  logic [7:0]            prev_levels [NUM_LEVELS];
  slot_vec_t             pending;
  logic [SlotW-1:0]      slot;

  // Decode side.
  logic [NUM_SWITCH-1:0] cur;
  logic [NUM_SWITCH-1:0] diff;
  slot_vec_t             sw_set;
  slot_vec_t             lvl_set;
  logic [15:0]           level_sum;
  logic [7:0]            gat_level;
  logic [LvlW-1:0]       gat_idx;
  logic                  gat_is_level;
  logic                  gat_finish;

  // Emit side.
  logic [LvlW-1:0]       prev_rd_idx;
  logic [7:0]            prev_lv;
  logic [7:0]            emit_status;
  logic [6:0]            emit_number;
  logic [6:0]            emit_value;
  logic                  emit_is_level;
  logic [4:0]            emit_bit;
  logic [LvlW-1:0]       emit_idx;
  slot_vec_t             slot_onehot;
  logic                  emit_fire;
  logic                  emit_last;

  assign s_tready = (state == IDLE);

  hrmd_report_buf #(
    .ReportBytes(ReportBytes)
  ) u_buf (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (s_tvalid && s_tready),
    .wr_data    (s_tdata),
    .wr_last    (s_tlast),
    .report_done(report_done),
    .rd_en      (rd_en),
    .rd_addr    (issue_addr),
    .rd_data    (rd_data)
  );

  assign rd_en = (state == GATHER) && !issue_done;

  // Level reading: (hi * 255 + lo) / 16, low 8 bits.
  always_comb begin
    level_sum    = {rd_data, 8'h00} - {8'h00, rd_data} + {8'h00, lo_q};
    gat_is_level = 1'b0;
    gat_level    = rd_data;
    gat_idx      = LvlW'(NUM_LEVELS - 1);
    if (rd_addr_q == AddrSelect) begin
      gat_is_level = rd_vld;
    end else if ((rd_addr_q > AddrLevel0) && rd_addr_q[0]) begin
      gat_is_level = rd_vld;
      gat_level    = level_sum[11:4];
      gat_idx      = LvlW'((rd_addr_q - AddrLevel0) >> 1);
    end
  end

  assign gat_finish = rd_vld && (rd_addr_q == AddrLast);

  // Switch word from the buffered bytes and its emission-order changes.
  always_comb begin
    cur = '0;
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < 4; x++) begin
        cur[4*y+x] = (y < 2) ? b1[7-4*(y%2)-x] : b2[7-4*(y%2)-x];
      end
    end
    for (int s = 0; s < 4; s++) begin
      cur[16+s] = b4[7-s];
    end
    for (int k = 0; k < 9; k++) begin
      cur[20+k] = BtnInFour[k] ? b4[BtnBit[k]] : b3[BtnBit[k]];
    end
    diff   = cur ^ prev_switches;
    sw_set = '0;
    for (int j = 0; j < SLOT_STOP; j++) begin
      sw_set[j] = diff[((j & 3) << 2) | (j >> 2)];
    end
    for (int j = SLOT_STOP; j < SLOT_LEVEL; j++) begin
      sw_set[j] = diff[j];
    end
    for (int j = SLOT_BUTTON; j < NUM_SLOTS; j++) begin
      sw_set[j] = diff[j - SLOT_BUTTON + SLOT_LEVEL];
    end
    if (!gat_finish) begin
      sw_set = '0;
    end
  end

  assign prev_rd_idx = (state == EMIT) ? emit_idx : gat_idx;
  assign prev_lv     = prev_levels[prev_rd_idx];

  always_comb begin
    lvl_set = '0;
    if (gat_is_level && (gat_level != prev_lv)) begin
      lvl_set[SlotW'(SLOT_LEVEL) + SlotW'(gat_idx)] = 1'b1;
    end
  end

  // Message fields for the slot under the scan pointer.
  always_comb begin
    emit_is_level = 1'b0;
    emit_idx      = '0;
    emit_bit      = '0;
    emit_status   = CTRL_CHANGE;
    emit_number   = '0;
    if (slot < SlotW'(SLOT_STOP)) begin
      emit_status = NOTE_ON;
      emit_bit    = {1'b0, slot[1:0], slot[3:2]};
      emit_number = PAD_NOTE_BASE + 7'(emit_bit);
    end else if (slot < SlotW'(SLOT_LEVEL)) begin
      emit_status = NOTE_ON;
      emit_bit    = 5'(slot);
      emit_number = STOP_NOTE_BASE + 7'(slot - SlotW'(SLOT_STOP));
    end else if (slot < SlotW'(SLOT_BUTTON)) begin
      emit_is_level = 1'b1;
      emit_idx      = LvlW'(slot - SlotW'(SLOT_LEVEL));
      emit_number   = LEVEL_CC_BASE + 7'(emit_idx);
    end else begin
      emit_bit    = 5'(slot - SlotW'(SLOT_BUTTON - SLOT_LEVEL));
      emit_number = BUTTON_CC_BASE + 7'(slot - SlotW'(SLOT_BUTTON));
    end
    if (emit_is_level) begin
      emit_value = prev_lv[7:1];
    end else begin
      emit_value = prev_switches[emit_bit] ? VALUE_ON : VALUE_OFF;
    end
  end

  always_comb begin
    slot_onehot       = '0;
    slot_onehot[slot] = 1'b1;
  end

  assign emit_fire = (state == EMIT) && (pending != '0) && pending[slot] &&
                     (!m_tvalid || m_tready);
  assign emit_last = ((pending & ~slot_onehot) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      issue_done    <= 1'b0;
      rd_vld        <= 1'b0;
      pending       <= '0;
      slot          <= '0;
      prev_switches <= '0;
      m_tvalid      <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        prev_levels[i] <= '0;
      end
    end else begin
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (report_done) begin
            state      <= GATHER;
            issue_addr <= AddrPadsLo;
            issue_done <= 1'b0;
            rd_vld     <= 1'b0;
            pending    <= '0;
          end
        end
        GATHER: begin
          rd_vld    <= rd_en;
          rd_addr_q <= issue_addr;
          if (rd_en) begin
            if (issue_addr == AddrLast) begin
              issue_done <= 1'b1;
            end else begin
              issue_addr <= issue_addr + AddrW'(1);
            end
          end
          if (rd_vld) begin
            if (rd_addr_q == AddrPadsLo) begin
              b1 <= rd_data;
            end
            if (rd_addr_q == AddrPadsHi) begin
              b2 <= rd_data;
            end
            if (rd_addr_q == AddrButtons) begin
              b3 <= rd_data;
            end
            if (rd_addr_q == AddrStops) begin
              b4 <= rd_data;
            end
            lo_q <= rd_data;
          end
          if (gat_is_level) begin
            prev_levels[gat_idx] <= gat_level;
          end
          pending <= pending | lvl_set | sw_set;
          if (gat_finish) begin
            prev_switches <= cur;
            slot          <= '0;
            state         <= EMIT;
          end
        end
        EMIT: begin
          if (pending == '0) begin
            state <= IDLE;
          end else if (!pending[slot]) begin
            slot <= slot + SlotW'(1);
          end else if (emit_fire) begin
            m_tdata  <= {2'b00, emit_value, emit_number, emit_status};
            m_tlast  <= emit_last;
            pending  <= pending & ~slot_onehot;
            // The pointer goes home after the final change so it never
            // runs past the last control.
            slot     <= emit_last ? '0 : slot + SlotW'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A complete report can only arrive while the block is collecting bytes.
  `HRMD_ASSERT_SAME(a_done_only_idle, report_done, state == IDLE)
  // Nothing is left marked once the block is back to collecting bytes.
  `HRMD_ASSERT_SAME(a_idle_no_pending, state == IDLE, pending == '0)
  // The message flagged as last leaves no further change behind it.
  `HRMD_ASSERT_NEXT(a_last_clears, emit_fire && emit_last, pending == '0)

endmodule

[tb/midi_change_pkg.sv]
`timescale 1ns / 1ps

package midi_change_pkg;
  import hrmd_pkg::*;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] number;
    logic [6:0] value;
    logic       last;
  } midi_msg_t;

  class midi_change_tracker;
    midi_msg_t   pending_msgs[$];
    int          errors;
    int          fill;
    logic [7:0]  report [REPORT_BYTES];
    logic [NUM_SWITCH-1:0] held_switches;
    logic [7:0]  held_levels [NUM_LEVELS];
    // Source byte and bit of each button, in controller order.
    int          button_byte [9] = '{3, 4, 4, 3, 3, 3, 4, 3, 3};
    int          button_bit  [9] = '{3, 1, 2, 6, 7, 4, 3, 5, 2};

    function new();
      errors = 0;
      fill = 0;
      held_switches = '0;
      foreach (held_levels[i]) held_levels[i] = 8'd0;
    endfunction

    task flag_mismatch(string what);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $time, what);
    endtask

    function void push_msg(logic [7:0] status, logic [6:0] number, logic [6:0] value);
      midi_msg_t m;
      m.status = status;
      m.number = number;
      m.value  = value;
      m.last   = 1'b0;
      pending_msgs.push_back(m);
    endfunction

    // Takes one accepted report byte; on a complete report it queues the
    // change messages that the block must send.
    function void take_byte(logic [7:0] b, logic eor);
      logic [NUM_SWITCH-1:0] now_sw;
      logic [NUM_SWITCH-1:0] diff;
      logic [7:0]            levels [NUM_LEVELS];
      int unsigned           lo;
      int unsigned           hi;
      int                    p;
      int                    queued;
      if (fill < REPORT_BYTES) begin
        report[fill] = b;
        fill++;
      end else begin
        fill = REPORT_BYTES + 1;
      end
      if (!eor) return;
      if (fill != REPORT_BYTES) begin
        fill = 0;
        return;
      end
      fill = 0;

      now_sw = '0;
      for (int y = 0; y < 4; y++) begin
        for (int x = 0; x < 4; x++) begin
          now_sw[4*y+x] = report[1 + y/2][7 - 4*(y%2) - x];
        end
      end
      for (int s = 0; s < 4; s++) now_sw[16+s] = report[4][7-s];
      for (int k = 0; k < 9; k++) now_sw[20+k] = report[button_byte[k]][button_bit[k]];
      for (int i = 0; i < 8; i++) begin
        lo = report[6 + 2*i];
        hi = report[7 + 2*i];
        levels[i] = 8'((hi * 255 + lo) / 16);
      end
      levels[8] = report[5];

      diff = now_sw ^ held_switches;
      queued = pending_msgs.size();
      // Pads go column by column, rows inside.
      for (int x = 0; x < 4; x++) begin
        for (int y = 0; y < 4; y++) begin
          p = 4*y + x;
          if (diff[p])
            push_msg(NOTE_ON, PAD_NOTE_BASE + 7'(p), now_sw[p] ? VALUE_ON : VALUE_OFF);
        end
      end
      for (int s = 0; s < 4; s++)
        if (diff[16+s])
          push_msg(NOTE_ON, STOP_NOTE_BASE + 7'(s), now_sw[16+s] ? VALUE_ON : VALUE_OFF);
      for (int i = 0; i < NUM_LEVELS; i++)
        if (levels[i] != held_levels[i])
          push_msg(CTRL_CHANGE, LEVEL_CC_BASE + 7'(i), levels[i][7:1]);
      for (int k = 0; k < 9; k++)
        if (diff[20+k])
          push_msg(CTRL_CHANGE, BUTTON_CC_BASE + 7'(k),
                   now_sw[20+k] ? VALUE_ON : VALUE_OFF);
      if (pending_msgs.size() > queued) pending_msgs[pending_msgs.size()-1].last = 1'b1;

      held_switches = now_sw;
      foreach (held_levels[i]) held_levels[i] = levels[i];
    endfunction

    // Compares one accepted output beat with the oldest queued message.
    task check_msg(logic [23:0] data, logic tl);
      midi_msg_t want;
      if (pending_msgs.size() == 0) begin
        flag_mismatch($sformatf("unexpected message %06h last %0b", data, tl));
        return;
      end
      want = pending_msgs.pop_front();
      if (data[7:0] !== want.status || data[14:8] !== want.number ||
          data[21:15] !== want.value || data[23:22] !== 2'b00 || tl !== want.last)
        flag_mismatch($sformatf("got %02h/%0d/%0d pad %0b last %0b, want %02h/%0d/%0d last %0b",
                                data[7:0], data[14:8], data[21:15], data[23:22], tl,
                                want.status, want.number, want.value, want.last));
    endtask
  endclass

endpackage

[tb/hid_report_to_midi_diff_unit_tb.sv]
`timescale 1ns / 1ps

// Streams controller reports into the block one byte per beat and checks
// every MIDI change message it sends against a software decode of the same
// reports. The run covers all-on and all-off reports, repeated reports that
// must stay silent, short and long transfers that must be dropped, and a
// random part built mostly from small edits of the previous report.
module hid_report_to_midi_diff_unit_tb;
  import hrmd_pkg::*;
  import midi_change_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] report_byte
  logic        s_tlast = 1'b0;   // end_of_report
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [7:0] status, [14:8] number, [21:15] value
  logic        m_tlast;          // last message of a report

  // Percent chance per cycle that the sender holds off or the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;

  midi_change_tracker tracker;

  // Bytes of the transfer about to be sent, and the last full report built,
  // which the random part edits to get realistic small changes.
  logic [7:0] frame_q[$];
  logic [7:0] shadow [REPORT_BYTES];

  hid_report_to_midi_diff_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver side. Handshake signals are read right after the edge, before
  // any nonblocking update of that edge lands, so they show the values the
  // block saw. Ready is then redrawn for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_msg(m_tdata, m_tlast);
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Sends one beat. A hold-off lowers valid first; without one, valid simply
  // stays high into the next beat so it gets a single update per edge.
  task automatic send_beat(input logic [7:0] b, input logic eor);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eor;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_byte(b, eor);
  endtask

  // Sends the queued bytes; when mark_end is set the final one carries tlast.
  task automatic send_frame(input bit mark_end);
    foreach (frame_q[i]) send_beat(frame_q[i], mark_end && (i == frame_q.size() - 1));
  endtask

  task automatic send_report();
    frame_q.delete();
    foreach (shadow[i]) frame_q.push_back(shadow[i]);
    send_frame(1'b1);
  endtask

  task automatic load_random(input int len);
    frame_q.delete();
    repeat (len) frame_q.push_back(8'($urandom));
  endtask

  initial begin
    int pick;
    int len;
    int sent;
    int idx;
    int bitn;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Everything on turns every control on at once, so all 38 messages
    // come out; everything off then turns them all back.
    foreach (shadow[i]) shadow[i] = 8'hFF;
    send_report();
    foreach (shadow[i]) shadow[i] = 8'h00;
    send_report();
    // The same report again changes nothing and must stay silent.
    send_report();
    // A short transfer, a one-byte transfer and an overlong transfer are
    // all dropped without output.
    load_random(3);
    send_frame(1'b1);
    load_random(1);
    send_frame(1'b1);
    frame_q.delete();
    repeat (24) frame_q.push_back(8'hFF);
    send_frame(1'b1);

    // Random part: first no idling, then a lazy sender, then a lazy
    // receiver, then both a little lazy.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 54;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 54;
        end
        default: begin
          idle_pct = 23;
          stall_pct = 23;
        end
      endcase
      sent = 0;
      while (sent < 30) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          // A few flipped bits: a pad or button press, a knob nudge.
          repeat ($urandom_range(1, 4)) begin
            idx = $urandom_range(REPORT_BYTES - 1);
            bitn = $urandom_range(7);
            shadow[idx][bitn] = ~shadow[idx][bitn];
          end
          send_report();
          sent += REPORT_BYTES;
        end else if (pick < 70) begin
          send_report();
          sent += REPORT_BYTES;
        end else if (pick < 80) begin
          foreach (shadow[i]) shadow[i] = 8'($urandom);
          send_report();
          sent += REPORT_BYTES;
        end else if (pick < 88) begin
          len = $urandom_range(1, REPORT_BYTES - 1);
          load_random(len);
          send_frame(1'b1);
          sent += len;
        end else if (pick < 95) begin
          len = $urandom_range(REPORT_BYTES + 1, REPORT_BYTES + 4);
          load_random(len);
          send_frame(1'b1);
          sent += len;
        end else begin
          // A transfer with no end mark runs into the next one; the joined transfer
          // is dropped as well unless its length comes to exactly one report.
          len = $urandom_range(1, 30);
          load_random(len);
          send_frame(1'b0);
          sent += len;
        end
      end
    end
    s_tvalid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    // Drain, then give the block time to show any message it should not send.
    while (tracker.pending_msgs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
